// ===== src/knnbc_pkg.sv =====
// Package for the k-nearest-neighbor binary classifier.
// Holds the shared widths, mode and cell operation codes, and the cell structs.
// No dependencies.
package knnbc_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_K_DEF       = 32;
  localparam int COORD_W         = 16;
  localparam int DIST_W          = 34;
  localparam int K_W             = 6;
  localparam int RES_W           = 6;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INSERT = 2'd2,
    OP_SHIFT  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic              label;
    logic [DIST_W-1:0] sq_dist;
  } entry_t;

  typedef struct packed {
    cell_op_t          op;
    logic              label;
    logic [DIST_W-1:0] sq_dist;
  } cell_cmd_t;

endpackage

// ===== src/knnbc_cell.sv =====
// One slot of the sorted neighbor list.
// Clears, inserts, shifts toward its neighbors, or drains; uses knnbc_pkg.
module knnbc_cell import knnbc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      en,
  input  logic      prev_lt,
  input  entry_t    prev_ent,
  input  entry_t    next_ent,
  output entry_t    ent,
  output logic      lt
);

  assign lt = en && (!ent.valid || (cmd.sq_dist < ent.sq_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_HOLD: begin
        end
        OP_CLEAR: begin
          ent.valid <= 1'b0;
        end
        OP_INSERT: begin
          if (lt && !prev_lt) begin
            ent.valid   <= 1'b1;
            ent.label   <= cmd.label;
            ent.sq_dist <= cmd.sq_dist;
          end else if (lt) begin
            ent <= prev_ent;
          end
        end
        OP_SHIFT: begin
          ent <= next_ent;
        end
      endcase
    end
  end

endmodule

// ===== src/knnbc_chain.sv =====
// Row of neighbor cells kept sorted by distance, nearest at cell 0.
// Instantiates knnbc_cell; uses knnbc_pkg.
module knnbc_chain import knnbc_pkg::*; #(
  parameter int NCELL = MAX_K_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_cmd_t        cmd,
  input  logic [NCELL-1:0] en,
  output entry_t           head
);

  entry_t           ents [NCELL];
  logic [NCELL-1:0] lts;
  entry_t           empty_ent;

  assign empty_ent = '0;
  assign head      = ents[0];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic   p_lt;
    entry_t p_ent;
    entry_t n_ent;

    if (i == 0) begin : g_first
      assign p_lt  = 1'b0;
      assign p_ent = empty_ent;
    end else begin : g_mid
      assign p_lt  = lts[i-1];
      assign p_ent = ents[i-1];
    end

    if (i == NCELL - 1) begin : g_last
      assign n_ent = empty_ent;
    end else begin : g_inner
      assign n_ent = ents[i+1];
    end

    knnbc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .en       (en[i]),
      .prev_lt  (p_lt),
      .prev_ent (p_ent),
      .next_ent (n_ent),
      .ent      (ents[i]),
      .lt       (lts[i])
    );
  end

endmodule

// ===== src/knnbc_dist.sv =====
// Three-stage squared Euclidean distance pipeline.
// Stage 1 absolute differences, stage 2 squares, stage 3 sum; uses knnbc_pkg.
module knnbc_dist import knnbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  logic signed [COORD_W-1:0] qx,
  input  logic signed [COORD_W-1:0] qy,
  input  logic signed [COORD_W-1:0] qz,
  input  logic signed [COORD_W-1:0] sx,
  input  logic signed [COORD_W-1:0] sy,
  input  logic signed [COORD_W-1:0] sz,
  input  logic                      slabel,
  output logic                      out_vld,
  output logic [DIST_W-1:0]         sq_dist,
  output logic                      label,
  output logic                      busy
);

  logic                      v1, v2;
  logic                      l1, l2;
  logic [COORD_W-1:0]        ax, ay, az;
  logic [2*COORD_W-1:0]      px, py, pz;
  logic signed [COORD_W:0]   dx, dy, dz;

  assign dx = qx - sx;
  assign dy = qy - sy;
  assign dz = qz - sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ax <= COORD_W'(dx[COORD_W] ? -dx : dx);
    ay <= COORD_W'(dy[COORD_W] ? -dy : dy);
    az <= COORD_W'(dz[COORD_W] ? -dz : dz);
    l1 <= slabel;
    px <= (2*COORD_W)'(ax) * (2*COORD_W)'(ax);
    py <= (2*COORD_W)'(ay) * (2*COORD_W)'(ay);
    pz <= (2*COORD_W)'(az) * (2*COORD_W)'(az);
    l2 <= l1;
    sq_dist <= DIST_W'(px) + DIST_W'(py) + DIST_W'(pz);
    label   <= l2;
  end

  assign busy = v1 || v2 || out_vld;

endmodule

// ===== src/knn_binary_classifier_unit.sv =====
// Top level of the k-nearest-neighbor binary classifier.
// Holds the sample memory and the query sequencer; uses knnbc_pkg, knnbc_dist, knnbc_chain.
//
// Input channel (in_valid/in_stall) carries one item per transfer: mode selects
// load (append a labelled sample), query (classify a point) or clear (empty the
// store and its overflow flag). Loads and clears give no result; a load into a
// full store is dropped and sets the overflow flag, reported as store_overflowed.
// A query scans the stored samples through the memory read port, one per cycle,
// into a 3-stage distance pipeline and a row of MAX_K sorted neighbor cells,
// then drains k cells to count the votes. The single memory read port and the
// k drain set how long a query takes. The result is held in an output register
// (out_valid/out_stall); while the receiver stalls, the block keeps taking loads,
// clears and one more query, but holds that query's result until the register is free.
// k_neighbors is written over the cfg_valid/cfg_ready channel; write it only while
// idle, which the block does not enforce. 0 acts as 1, above MAX_K acts as MAX_K.
// Synchronous reset empties the store, clears the overflow flag, sets k to 1
// and drops any pending result; memory contents are left as they are.
module knn_binary_classifier_unit import knnbc_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int MAX_K       = MAX_K_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic                      sample_label,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RES_W-1:0]          votes_true,
  output logic [RES_W-1:0]          neighbors_used,
  output logic                      predicted_label,
  output logic                      short_set,
  output logic                      store_overflowed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [K_W-1:0]            cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int KC_W   = $clog2(MAX_K + 1);
  localparam int MEM_W  = 3 * COORD_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [K_W-1:0]     k_neighbors;
  logic [CNT_W-1:0]   sample_count;
  logic               overflow_flag;
  logic [MEM_W-1:0]   mem [MAX_SAMPLES];
  logic [MEM_W-1:0]   rd_data;
  logic               rd_valid;
  logic [CNT_W-1:0]   issue_cnt;
  logic               issuing;

  logic signed [COORD_W-1:0] qx, qy, qz;
  logic [KC_W-1:0]    keff_q, used_q;
  logic               short_q;
  logic [KC_W-1:0]    votes, drain_cnt;

  logic [K_W:0]       k_ext, keff7;
  logic [KC_W-1:0]    keff_now;
  logic               take, take_load, take_query, take_clear, store_full;
  logic               fin_fire;

  logic               d_vld, d_label, d_busy;
  logic [DIST_W-1:0]  d_dist;
  cell_cmd_t          cmd;
  logic [MAX_K-1:0]   cell_en;
  entry_t             head;
  logic [KC_W:0]      twice_votes;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  assign take       = in_valid && !in_stall;
  assign take_load  = take && (mode == MODE_LOAD);
  assign take_query = take && (mode == MODE_QUERY);
  assign take_clear = take && (mode == MODE_CLEAR);
  assign store_full = (sample_count == CNT_W'(MAX_SAMPLES));

  assign k_ext    = {1'b0, k_neighbors};
  assign keff7    = (k_neighbors == '0) ? (K_W+1)'(1) :
                    ((k_ext > (K_W+1)'(MAX_K)) ? (K_W+1)'(MAX_K) : k_ext);
  assign keff_now = KC_W'(keff7);

  assign issuing  = (state == ST_SCAN) && (issue_cnt < sample_count);
  assign fin_fire = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      cell_en[i] = (i < int'(keff_q));
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take_query) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issuing && !rd_valid && !d_busy) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drain_cnt == KC_W'(1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = OP_HOLD;
    cmd.sq_dist = d_dist;
    cmd.label   = d_label;
    if (take_query) begin
      cmd.op = OP_CLEAR;
    end else if ((state == ST_SCAN) && d_vld) begin
      cmd.op = OP_INSERT;
    end else if (state == ST_DRAIN) begin
      cmd.op = OP_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      k_neighbors   <= K_W'(1);
      sample_count  <= '0;
      overflow_flag <= 1'b0;
      rd_valid      <= 1'b0;
      issue_cnt     <= '0;
      drain_cnt     <= '0;
      out_valid     <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issuing;
      if (cfg_valid && cfg_ready) k_neighbors <= cfg_data;
      if (take_load) begin
        if (store_full) overflow_flag <= 1'b1;
        else            sample_count  <= sample_count + CNT_W'(1);
      end
      if (take_clear) begin
        sample_count  <= '0;
        overflow_flag <= 1'b0;
      end
      if (take_query) issue_cnt <= '0;
      else if (issuing) issue_cnt <= issue_cnt + CNT_W'(1);
      if (state == ST_SCAN) drain_cnt <= keff_q;
      else if (state == ST_DRAIN) drain_cnt <= drain_cnt - KC_W'(1);
      if (fin_fire) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_load && !store_full) begin
      mem[sample_count[ADDR_W-1:0]] <= {coord_x, coord_y, coord_z, sample_label};
    end
    if (issuing) begin
      rd_data <= mem[issue_cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      qx      <= coord_x;
      qy      <= coord_y;
      qz      <= coord_z;
      keff_q  <= keff_now;
      short_q <= (32'(sample_count) < 32'(keff_now));
      used_q  <= (32'(sample_count) < 32'(keff_now)) ? KC_W'(sample_count) : keff_now;
      votes   <= '0;
    end else if ((state == ST_DRAIN) && head.valid && head.label) begin
      votes <= votes + KC_W'(1);
    end
  end

  assign twice_votes = {votes, 1'b0};

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      votes_true       <= RES_W'(votes);
      neighbors_used   <= RES_W'(used_q);
      predicted_label  <= (twice_votes >= {1'b0, used_q});
      short_set        <= short_q;
      store_overflowed <= overflow_flag;
    end
  end

  knnbc_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (rd_valid),
    .qx      (qx),
    .qy      (qy),
    .qz      (qz),
    .sx      (rd_data[3*COORD_W:2*COORD_W+1]),
    .sy      (rd_data[2*COORD_W:COORD_W+1]),
    .sz      (rd_data[COORD_W:1]),
    .slabel  (rd_data[0]),
    .out_vld (d_vld),
    .sq_dist (d_dist),
    .label   (d_label),
    .busy    (d_busy)
  );

  knnbc_chain #(
    .NCELL (MAX_K)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .en   (cell_en),
    .head (head)
  );

endmodule

// ===== src/knnbc_checker.sv =====
// Port-level checks for the classifier top level, attached by bind.
// Uses knnbc_pkg; binds to knn_binary_classifier_unit.
module knnbc_checker import knnbc_pkg::*; #(
  parameter int MAX_K = MAX_K_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       mode,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RES_W-1:0] votes_true,
  input logic [RES_W-1:0] neighbors_used,
  input logic             predicted_label
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(votes_true) && $stable(neighbors_used))
    else $error("stalled result changed");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_QUERY) |=> in_stall)
    else $error("input not stalled during query");

  a_votes_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_K > 63) || (votes_true <= neighbors_used))
    else $error("more votes than neighbors");

  a_majority: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (MAX_K > 63) ||
      (predicted_label == ({votes_true, 1'b0} >= {1'b0, neighbors_used})))
    else $error("predicted label inconsistent with votes");

endmodule

bind knn_binary_classifier_unit knnbc_checker #(.MAX_K(MAX_K)) u_knnbc_checker (.*);

// ===== test/knn_binary_classifier_checker.sv =====
// Checker for knn_binary_classifier_unit: watches the input, result and k write
// channels, predicts each query result from its own copy of the sample store
// and compares it field by field. Depends on knnbc_pkg.
module knn_binary_classifier_checker import knnbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic                      sample_label,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [RES_W-1:0]          votes_true,
  input  logic [RES_W-1:0]          neighbors_used,
  input  logic                      predicted_label,
  input  logic                      short_set,
  input  logic                      store_overflowed,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [K_W-1:0]            cfg_data,
  output int                        errors,
  output int                        pending
);

  typedef struct packed {
    logic [RES_W-1:0] votes;
    logic [RES_W-1:0] used;
    logic             majority;
    logic             short_flag;
    logic             overflow;
  } verdict_t;

  logic signed [COORD_W-1:0] pts_x [MAX_SAMPLES_DEF];
  logic signed [COORD_W-1:0] pts_y [MAX_SAMPLES_DEF];
  logic signed [COORD_W-1:0] pts_z [MAX_SAMPLES_DEF];
  logic                      pts_label [MAX_SAMPLES_DEF];
  int                        stored;
  logic                      overflowed;
  logic [K_W-1:0]            k_reg;
  verdict_t                  verdicts_due [$];
  verdict_t                  want;

  task automatic report(input string what, input int got, input int exp_val);
    errors++;
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, exp_val);
  endtask

  // keeps the k nearest in distance order; a later sample only displaces a
  // kept one when strictly nearer, so ties go to the earlier load
  function automatic verdict_t classify_point(input logic signed [COORD_W-1:0] qx,
                                              input logic signed [COORD_W-1:0] qy,
                                              input logic signed [COORD_W-1:0] qz);
    logic [DIST_W-1:0] best_d [MAX_K_DEF];
    logic              best_l [MAX_K_DEF];
    logic [DIST_W-1:0] d;
    int                keff, kept, slot, i, j, votes, used, dx, dy, dz;
    verdict_t          v;
    keff = (k_reg == 0) ? 1 : ((int'(k_reg) > MAX_K_DEF) ? MAX_K_DEF : int'(k_reg));
    kept = 0;
    for (i = 0; i < stored; i++) begin
      dx = int'(qx) - int'(pts_x[i]);
      dy = int'(qy) - int'(pts_y[i]);
      dz = int'(qz) - int'(pts_z[i]);
      d = DIST_W'(longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz);
      slot = kept;
      while (slot > 0 && d < best_d[slot-1])
        slot--;
      if (slot < keff) begin
        j = (kept < keff) ? kept : keff - 1;
        while (j > slot) begin
          best_d[j] = best_d[j-1];
          best_l[j] = best_l[j-1];
          j--;
        end
        best_d[slot] = d;
        best_l[slot] = pts_label[i];
        if (kept < keff)
          kept++;
      end
    end
    votes = 0;
    for (i = 0; i < kept; i++)
      votes += best_l[i];
    used = (stored < keff) ? stored : keff;
    v.votes      = RES_W'(votes);
    v.used       = RES_W'(used);
    v.majority   = (2 * votes >= used);
    v.short_flag = (stored < keff);
    v.overflow   = overflowed;
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      stored     = 0;
      overflowed = 1'b0;
      k_reg      = K_W'(1);
      verdicts_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          report("result with no query waiting, votes_true", votes_true, 0);
        end else begin
          want = verdicts_due.pop_front();
          if (votes_true !== want.votes)
            report("votes_true", votes_true, want.votes);
          if (neighbors_used !== want.used)
            report("neighbors_used", neighbors_used, want.used);
          if (predicted_label !== want.majority)
            report("predicted_label", predicted_label, want.majority);
          if (short_set !== want.short_flag)
            report("short_set", short_set, want.short_flag);
          if (store_overflowed !== want.overflow)
            report("store_overflowed", store_overflowed, want.overflow);
        end
      end
      if (in_valid && !in_stall) begin
        case (mode)
          MODE_LOAD: begin
            if (stored < MAX_SAMPLES_DEF) begin
              pts_x[stored]     = coord_x;
              pts_y[stored]     = coord_y;
              pts_z[stored]     = coord_z;
              pts_label[stored] = sample_label;
              stored++;
            end else begin
              overflowed = 1'b1;
            end
          end
          MODE_CLEAR: begin
            stored     = 0;
            overflowed = 1'b0;
          end
          MODE_QUERY: verdicts_due = {verdicts_due, classify_point(coord_x, coord_y, coord_z)};
          default: ;
        endcase
      end
      if (cfg_valid && cfg_ready)
        k_reg = cfg_data;
    end
    pending = verdicts_due.size();
  end

endmodule

// ===== test/knn_binary_classifier_unit_tb.sv =====
// Testbench top for knn_binary_classifier_unit: drives load, query and clear
// transfers and k writes with random idling on both channels and gives the verdict.
// Depends on knnbc_pkg and knn_binary_classifier_checker.
module knn_binary_classifier_unit_tb;
  import knnbc_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         LONG_HOLD     = 400;
  localparam int         PHASE_ITEMS   = 56;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                mode = MODE_LOAD;
  logic signed [COORD_W-1:0] coord_x = '0;
  logic signed [COORD_W-1:0] coord_y = '0;
  logic signed [COORD_W-1:0] coord_z = '0;
  logic                      sample_label = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [RES_W-1:0]          votes_true;
  logic [RES_W-1:0]          neighbors_used;
  logic                      predicted_label;
  logic                      short_set;
  logic                      store_overflowed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [K_W-1:0]            cfg_data = '0;
  int                        errors;
  int                        pending;
  bit                        hold_req = 1'b0;
  bit                        no_gaps = 1'b0;

  always #2 clk = ~clk;

  knn_binary_classifier_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .coord_z          (coord_z),
    .sample_label     (sample_label),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .votes_true       (votes_true),
    .neighbors_used   (neighbors_used),
    .predicted_label  (predicted_label),
    .short_set        (short_set),
    .store_overflowed (store_overflowed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  knn_binary_classifier_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .coord_z          (coord_z),
    .sample_label     (sample_label),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .votes_true       (votes_true),
    .neighbors_used   (neighbors_used),
    .predicted_label  (predicted_label),
    .short_set        (short_set),
    .store_overflowed (store_overflowed),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .errors           (errors),
    .pending          (pending)
  );

  // 0: full range, 1: tight cluster (many equal distances), 2: extremes
  function automatic logic signed [COORD_W-1:0] rand_coord(input int style);
    logic [COORD_W-1:0] r;
    case (style)
      0: r = COORD_W'($urandom);
      1: r = COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
      default: begin
        case ($urandom_range(0, 4))
          0: r = 16'h8000;
          1: r = 16'h7fff;
          2: r = 16'h0000;
          3: r = 16'hffff;
          default: r = 16'h0001;
        endcase
      end
    endcase
    return $signed(r);
  endfunction

  task automatic idle_gap();
    int roll, n;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55)
      n = 0;
    else if (roll < 88)
      n = $urandom_range(1, 3);
    else if (roll < 97)
      n = $urandom_range(4, 12);
    else
      n = $urandom_range(13, 40);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(input logic [1:0] m,
                           input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic signed [COORD_W-1:0] z,
                           input logic lbl);
    bit taken;
    idle_gap();
    in_valid     <= 1'b1;
    mode         <= m;
    coord_x      <= x;
    coord_y      <= y;
    coord_z      <= z;
    sample_label <= lbl;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic write_k(input logic [K_W-1:0] v);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // all queries answered, then room for a trailing load or clear to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic query_at(input int style);
    send_item(MODE_QUERY, rand_coord(style), rand_coord(style), rand_coord(style),
              1'($urandom_range(0, 1)));
  endtask

  task automatic load_at(input int style);
    send_item(MODE_LOAD, rand_coord(style), rand_coord(style), rand_coord(style),
              1'($urandom_range(0, 1)));
  endtask

  task automatic run_sequence(inout int counted);
    int         style, nload, nq;
    logic [1:0] m;
    style = $urandom_range(0, 2);
    if ($urandom_range(0, 99) < 85) begin
      if ($urandom_range(0, 2) == 0) begin
        send_item(MODE_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0),
                  1'($urandom_range(0, 1)));
        counted++;
      end
      nload = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      repeat (nload) begin
        load_at(style);
        counted++;
      end
      nq = $urandom_range(1, 4);
      repeat (nq) begin
        query_at(($urandom_range(0, 3) == 0) ? 0 : style);
        counted++;
      end
    end else begin
      repeat ($urandom_range(1, 3)) begin
        m = 2'($urandom_range(0, 3));
        send_item(m, rand_coord(0), rand_coord(0), rand_coord(0), 1'($urandom_range(0, 1)));
        if (m != MODE_UNUSED)
          counted++;
      end
    end
  endtask

  initial begin : sink
    int run_left, hold_left, roll;
    bit hold_done;
    run_left  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(50, 200);
        end else if (roll < 50) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 20);
        end else if (roll < 85) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 2);
        end else if (roll < 97) begin
          out_stall <= 1'b1;
          run_left = $urandom_range(3, 10);
        end else begin
          out_stall <= 1'b1;
          run_left = $urandom_range(11, 40);
        end
      end
    end
  end

  initial begin : stimulus
    int             counted, phase;
    logic [K_W-1:0] k_plan [10];
    k_plan = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd33, 6'd7, 6'd2, 6'd16, 6'd0, 6'd0};
    k_plan[8] = K_W'($urandom_range(0, 63));
    k_plan[9] = K_W'($urandom_range(0, 63));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: k = 1 from reset
    send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(MODE_LOAD, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    send_item(MODE_LOAD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
    send_item(MODE_LOAD, 16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_item(MODE_LOAD, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(MODE_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
    send_item(MODE_QUERY, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
    send_item(MODE_UNUSED, 16'sd5, 16'sd5, 16'sd5, 1'b1);
    send_item(MODE_QUERY, 16'sd1, -16'sd1, 16'sd0, 1'b1);
    settle();
    write_k(6'd63);
    send_item(MODE_QUERY, 16'sd100, -16'sd100, 16'sd7, 1'b0);
    settle();
    write_k(6'd0);
    send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    settle();
    write_k(6'd2);
    send_item(MODE_QUERY, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(MODE_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_item(MODE_QUERY, 16'sh7fff, 16'sh8000, 16'sd0, 1'b1);

    // full store, dropped loads, sticky flag cleared by clear
    settle();
    write_k(6'd32);
    no_gaps = 1'b1;
    repeat (MAX_SAMPLES_DEF) load_at(0);
    no_gaps = 1'b0;
    repeat (2) query_at(0);
    repeat (2) load_at(1);
    query_at(1);
    send_item(MODE_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    query_at(0);
    load_at(0);
    query_at(0);

    for (phase = 0; phase < 10; phase++) begin
      settle();
      write_k(k_plan[phase]);
      no_gaps = (phase == 3);
      counted = 0;
      if (phase == 5) begin
        // receiver holds off while queries keep coming: the block backs up
        send_item(MODE_CLEAR, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        repeat (8) load_at(1);
        hold_req = 1'b1;
        repeat (8) query_at(1);
        counted = 17;
      end
      while (counted < PHASE_ITEMS)
        run_sequence(counted);
    end
    no_gaps = 1'b0;
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
